// ===== rtl/gasp_pkg.sv =====
package gasp_pkg;

  localparam int unsigned FieldW = 12;
  localparam int unsigned PageW  = 8;
  localparam int unsigned RegW   = 13;
  localparam int unsigned IdxW   = 1;

  localparam logic [RegW-1:0] RegReset = 13'd1024;

  localparam logic [IdxW-1:0] REG_ATLAS_WIDTH  = 1'b0;
  localparam logic [IdxW-1:0] REG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic pages_exhausted;
    logic opened_page;
    logic too_big;
  } flags_t;

endpackage

// ===== rtl/gasp_place.sv =====
module gasp_place #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned MAX_PAGES  = 256
) (
  input  logic [gasp_pkg::RegW-1:0]  atlas_width_i,
  input  logic [gasp_pkg::RegW-1:0]  atlas_height_i,
  input  logic [COORD_BITS-1:0]      rect_w_i,
  input  logic [COORD_BITS-1:0]      rect_h_i,
  input  logic [COORD_BITS-1:0]      cur_x_i,
  input  logic [COORD_BITS-1:0]      cur_y_i,
  input  logic [COORD_BITS-1:0]      row_h_i,
  input  logic [gasp_pkg::PageW-1:0] page_i,
  output logic [COORD_BITS-1:0]      place_x_o,
  output logic [COORD_BITS-1:0]      place_y_o,
  output logic [gasp_pkg::PageW-1:0] place_page_o,
  output gasp_pkg::flags_t           flags_o,
  output logic [COORD_BITS-1:0]      nxt_x_o,
  output logic [COORD_BITS-1:0]      nxt_y_o,
  output logic [COORD_BITS-1:0]      nxt_row_o,
  output logic [gasp_pkg::PageW-1:0] nxt_page_o
);

  localparam int unsigned SumW = (COORD_BITS + 1 > gasp_pkg::RegW + 1) ?
                                 COORD_BITS + 1 : gasp_pkg::RegW + 1;
  localparam int unsigned CntW = gasp_pkg::PageW + 1;

  logic [SumW-1:0]                aw, ah, w_e, h_e;
  logic                           too_big, new_row, new_page, page_full;
  logic [COORD_BITS-1:0]          x1, y1, row1, y2;
  logic [CntW-1:0]                page_inc;
  logic [gasp_pkg::PageW-1:0]     page1;

  always_comb begin
    aw  = SumW'(atlas_width_i);
    ah  = SumW'(atlas_height_i);
    w_e = SumW'(rect_w_i);
    h_e = SumW'(rect_h_i);

    too_big = (w_e >= aw) || (h_e >= ah);

    new_row = (SumW'(cur_x_i) + w_e) >= aw;
    x1      = new_row ? '0 : cur_x_i;
    y1      = new_row ? (cur_y_i + row_h_i) : cur_y_i;
    row1    = new_row ? '0 : row_h_i;

    new_page  = (SumW'(y1) + h_e) >= ah;
    page_inc  = CntW'(page_i) + CntW'(1);
    page_full = page_inc >= CntW'(MAX_PAGES);
    page1     = (new_page && !page_full) ? page_inc[gasp_pkg::PageW-1:0] : page_i;
    y2        = new_page ? '0 : y1;

    if (too_big) begin
      place_x_o    = '0;
      place_y_o    = '0;
      place_page_o = '0;
      flags_o      = '{pages_exhausted: 1'b0, opened_page: 1'b0, too_big: 1'b1};
      nxt_x_o      = cur_x_i;
      nxt_y_o      = cur_y_i;
      nxt_row_o    = row_h_i;
      nxt_page_o   = page_i;
    end else begin
      place_x_o    = x1;
      place_y_o    = y2;
      place_page_o = page1;
      flags_o      = '{pages_exhausted: new_page && page_full,
                       opened_page:     new_page && !page_full,
                       too_big:         1'b0};
      nxt_x_o      = x1 + rect_w_i;
      nxt_y_o      = y2;
      nxt_row_o    = (rect_h_i > row1) ? rect_h_i : row1;
      nxt_page_o   = page1;
    end
  end

endmodule

// ===== rtl/glyph_atlas_shelf_packer.sv =====
// Path: an accepted request is held in the input register, and its result in the output register on the master side.
// Throughput: one request per cycle while the master side accepts results; the cursor,
// row height and page count are updated combinationally from the input register, which closes the loop.
// Reset: cursor, row height and page count clear to zero, atlas width and height
// return to 1024, and both stages empty.
module glyph_atlas_shelf_packer #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned MAX_PAGES  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rect_width[11:0], rect_height[23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // place_x[11:0], place_y[23:12], page_index[31:24]
  output logic [2:0]  m_axis_tuser,   // too_big[0], opened_page[1], pages_exhausted[2]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [gasp_pkg::IdxW-1:0] cfg_addr_i,
  input  logic [gasp_pkg::RegW-1:0] cfg_data_i
);

  localparam int unsigned FW = gasp_pkg::FieldW;
  localparam int unsigned PW = gasp_pkg::PageW;

  logic [gasp_pkg::RegW-1:0] atlas_w_q, atlas_h_q;
  logic                      in_v_q, out_v_q, advance;
  logic [COORD_BITS-1:0]     rect_w_q, rect_h_q;
  logic [COORD_BITS-1:0]     cur_x_q, cur_y_q, row_h_q;
  logic [PW-1:0]             page_q;
  logic [COORD_BITS-1:0]     place_x, place_y, cur_x_d, cur_y_d, row_h_d;
  logic [PW-1:0]             place_page, page_d;
  gasp_pkg::flags_t          flags;
  logic [FW-1:0]             out_x_q, out_y_q;
  logic [PW-1:0]             out_page_q;
  gasp_pkg::flags_t          out_flags_q;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= gasp_pkg::RegReset;
      atlas_h_q <= gasp_pkg::RegReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        gasp_pkg::REG_ATLAS_WIDTH:  atlas_w_q <= cfg_data_i;
        gasp_pkg::REG_ATLAS_HEIGHT: atlas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rect_w_q <= COORD_BITS'(s_axis_tdata[FW-1:0]);
      rect_h_q <= COORD_BITS'(s_axis_tdata[2*FW-1:FW]);
    end
  end

  gasp_place #(
    .COORD_BITS (COORD_BITS),
    .MAX_PAGES  (MAX_PAGES)
  ) u_place (
    .atlas_width_i  (atlas_w_q),
    .atlas_height_i (atlas_h_q),
    .rect_w_i       (rect_w_q),
    .rect_h_i       (rect_h_q),
    .cur_x_i        (cur_x_q),
    .cur_y_i        (cur_y_q),
    .row_h_i        (row_h_q),
    .page_i         (page_q),
    .place_x_o      (place_x),
    .place_y_o      (place_y),
    .place_page_o   (place_page),
    .flags_o        (flags),
    .nxt_x_o        (cur_x_d),
    .nxt_y_o        (cur_y_d),
    .nxt_row_o      (row_h_d),
    .nxt_page_o     (page_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      row_h_q <= '0;
      page_q  <= '0;
    end else if (advance) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      row_h_q <= row_h_d;
      page_q  <= page_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_x_q     <= FW'(place_x);
      out_y_q     <= FW'(place_y);
      out_page_q  <= place_page;
      out_flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_page_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_flags_q;

  a_page_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(page_q) < MAX_PAGES)
    else $error("page count beyond limit");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(flags.opened_page && flags.pages_exhausted) &&
                !(flags.too_big && (flags.opened_page || flags.pages_exhausted)))
    else $error("conflicting result flags");

  a_reject_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && flags.too_big |=>
      $stable(cur_x_q) && $stable(cur_y_q) && $stable(row_h_q) && $stable(page_q))
    else $error("rejected rectangle changed the cursor");

  a_new_page_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && flags.opened_page |=> cur_y_q == '0 && page_q == $past(page_q) + 1'b1)
    else $error("new page did not restart at the top");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready)
    else $error("input stalled with empty result stage");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned PageLimit = 256;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned RegBits = gasp_pkg::RegW;

  typedef struct packed {
    logic [11:0]      x;
    logic [11:0]      y;
    logic [7:0]       page;
    gasp_pkg::flags_t flags;
  } spot_t;

  class shelf_tracker;
    logic [gasp_pkg::RegW-1:0] atlas_w = gasp_pkg::RegReset;
    logic [gasp_pkg::RegW-1:0] atlas_h = gasp_pkg::RegReset;
    logic [11:0] cur_x = '0;
    logic [11:0] cur_y = '0;
    logic [11:0] row_h = '0;
    logic [7:0]  page = '0;
    spot_t spots[$];
    int unsigned errors = 0;
    int unsigned placed = 0;
    int unsigned rejected = 0;
    int unsigned opened = 0;
    int unsigned exhausted = 0;

    function void write_reg(logic [gasp_pkg::IdxW-1:0] idx, logic [gasp_pkg::RegW-1:0] val);
      if (idx == gasp_pkg::REG_ATLAS_WIDTH) atlas_w = val;
      else if (idx == gasp_pkg::REG_ATLAS_HEIGHT) atlas_h = val;
    endfunction

    function void place_rect(logic [11:0] w, logic [11:0] h);
      spot_t s;
      s = '0;
      if (32'(w) >= 32'(atlas_w) || 32'(h) >= 32'(atlas_h)) begin
        s.flags.too_big = 1'b1;
      end else begin
        if (32'(cur_x) + 32'(w) >= 32'(atlas_w)) begin
          cur_x = '0;
          cur_y = cur_y + row_h;
          row_h = '0;
        end
        if (32'(cur_y) + 32'(h) >= 32'(atlas_h)) begin
          if (32'(page) + 1 >= PageLimit) begin
            s.flags.pages_exhausted = 1'b1;
          end else begin
            page = page + 8'd1;
            s.flags.opened_page = 1'b1;
          end
          cur_y = '0;
        end
        s.x = cur_x;
        s.y = cur_y;
        s.page = page;
        cur_x = cur_x + w;
        if (h > row_h) row_h = h;
      end
      spots.push_back(s);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_spot(logic [31:0] data, logic [2:0] user);
      spot_t want;
      spot_t got;
      got.x = data[11:0];
      got.y = data[23:12];
      got.page = data[31:24];
      got.flags = gasp_pkg::flags_t'(user);
      if (spots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, x %0d y %0d page %0d flags %b",
                 $time, got.x, got.y, got.page, user);
        return;
      end
      want = spots.pop_front();
      if (got.x !== want.x) report("place_x", want.x, got.x);
      if (got.y !== want.y) report("place_y", want.y, got.y);
      if (got.page !== want.page) report("page_index", want.page, got.page);
      if (got.flags.too_big !== want.flags.too_big)
        report("too_big", want.flags.too_big, got.flags.too_big);
      if (got.flags.opened_page !== want.flags.opened_page)
        report("opened_page", want.flags.opened_page, got.flags.opened_page);
      if (got.flags.pages_exhausted !== want.flags.pages_exhausted)
        report("pages_exhausted", want.flags.pages_exhausted, got.flags.pages_exhausted);
      if (want.flags.too_big) rejected++;
      else placed++;
      if (want.flags.opened_page) opened++;
      if (want.flags.pages_exhausted) exhausted++;
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [23:0]               s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [31:0]               m_axis_tdata;
  logic [2:0]                m_axis_tuser;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [gasp_pkg::IdxW-1:0] cfg_addr_i;
  logic [gasp_pkg::RegW-1:0] cfg_data_i;

  shelf_tracker board;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet = 0;
  int unsigned settings_seen = 1;

  glyph_atlas_shelf_packer #(
    .COORD_BITS(CoordBits),
    .MAX_PAGES (PageLimit)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_spot(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        board.place_rect(s_axis_tdata[11:0], s_axis_tdata[23:12]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, QuietLimit);
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_rect(logic [11:0] w, logic [11:0] h);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.spots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [gasp_pkg::IdxW-1:0] idx, logic [gasp_pkg::RegW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [11:0] pick_dim(int unsigned limit, int unsigned spread);
    int unsigned r;
    int unsigned top;
    r = $urandom_range(99);
    if (r < 4) return 12'd0;
    if (r < 12 || limit == 0) return 12'($urandom_range(4095));
    if (r < 18) begin
      top = limit - $urandom_range(1, 0);
      return (top > 4095) ? 12'd4095 : 12'(top);
    end
    top = limit * spread / 100;
    if (top > 4095) top = 4095;
    return 12'($urandom_range(top));
  endfunction

  task automatic run_phase(int unsigned aw, int unsigned ah, int unsigned count,
                           int unsigned spread, int unsigned profile);
    wait_drain();
    write_reg(gasp_pkg::REG_ATLAS_WIDTH, RegBits'(aw));
    write_reg(gasp_pkg::REG_ATLAS_HEIGHT, RegBits'(ah));
    settings_seen++;
    case (profile % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 88; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 88; end
      default: begin send_idle = 19; recv_stall = 19; end
    endcase
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drain();
      send_rect(pick_dim(aw, spread), pick_dim(ah, spread));
    end
  endtask

  initial begin
    board = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= gasp_pkg::REG_ATLAS_WIDTH;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_rect(12'd0, 12'd0);
    send_rect(12'd4095, 12'd0);
    send_rect(12'd0, 12'd4095);
    send_rect(12'd1024, 12'd1);
    send_rect(12'd1, 12'd1024);
    send_rect(12'd1023, 12'd5);
    send_rect(12'd5, 12'd1023);
    send_rect(12'hAAA, 12'h555);
    send_rect(12'h555, 12'hAAA);
    send_rect(12'd600, 12'd100);
    send_rect(12'd600, 12'd200);
    send_rect(12'd100, 12'd700);
    send_rect(12'd1000, 12'd10);
    send_rect(12'd500, 12'd1000);
    send_rect(12'd523, 12'd3);
    send_rect(12'd1, 12'd1);
    send_rect(12'd1022, 12'd1022);
    send_rect(12'd1022, 12'd1022);
    send_rect(12'd0, 12'd1022);

    run_phase(4096, 4096, 150, 25, 0);
    run_phase(37, 53, 150, 40, 1);
    run_phase(1, 1, 40, 100, 2);
    run_phase(0, 4096, 30, 30, 3);
    run_phase(4096, 64, 150, 30, 0);
    run_phase(64, 4096, 150, 30, 1);
    run_phase(200, 150, 150, 40, 2);
    run_phase(4, 4, 450, 100, 3);
    run_phase(1000, 700, 150, 30, 0);
    run_phase(8191, 8191, 100, 20, 3);
    run_phase(1024, 1024, 150, 30, 2);

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d rectangles placed and %0d rejected as too big over %0d atlas sizes",
             board.placed, board.rejected, settings_seen);
    $display("tb: %0d pages opened, %0d placements with the page count exhausted",
             board.opened, board.exhausted);
    if (board.errors == 0 && board.spots.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
